FILE: src/apq_pkg.sv
// apq_pkg: shared types and codes for the array priority queue.
// Used by apq_front, apq_fifo, apq_back, array_priority_queue and apq_checker.
`default_nettype none

package apq_pkg;

    // fixed field widths
    localparam int VALUE_W    = 32;
    localparam int ITEM_PRI_W = 8;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 7;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // action codes on the command port
    localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PEEK    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // operation class decided by the front
    typedef enum logic [1:0] {
        OP_ENQ,
        OP_PEEK,
        OP_DEQ,
        OP_NOP
    } op_t;

    // one queued command
    typedef struct packed {
        op_t                          op;
        logic signed [VALUE_W-1:0]    value;
        logic        [ITEM_PRI_W-1:0] pri;
    } cmd_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_SHIFT
    } bk_state_t;

endpackage

`default_nettype wire

FILE: src/apq_front.sv
// apq_front: accepts start commands and classifies the action into an operation.
// Depends on apq_pkg; feeds apq_fifo.
`default_nettype none

module apq_front (
    input  wire logic                                start,
    input  wire logic [apq_pkg::ACTION_W-1:0]        action,
    input  wire logic signed [apq_pkg::VALUE_W-1:0]  item_value,
    input  wire logic [apq_pkg::ITEM_PRI_W-1:0]      item_priority,
    input  wire logic                                queue_full,
    output logic                                     busy,
    output logic                                     push,
    output apq_pkg::cmd_t                            push_cmd
);

    // hold off new transactions while the queue has no room
    assign busy = queue_full;
    assign push = start && !queue_full;

    // action decode; the unused code becomes a no-op
    always_comb
    begin
        push_cmd.value = item_value;
        push_cmd.pri   = item_priority;
        unique case (action)
            apq_pkg::ACT_ENQUEUE: push_cmd.op = apq_pkg::OP_ENQ;
            apq_pkg::ACT_PEEK:    push_cmd.op = apq_pkg::OP_PEEK;
            apq_pkg::ACT_DEQUEUE: push_cmd.op = apq_pkg::OP_DEQ;
            default:              push_cmd.op = apq_pkg::OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/apq_fifo.sv
// apq_fifo: short command queue between the front and the back.
// Depends on apq_pkg (cmd_t, QUEUE_DEPTH).
`default_nettype none

module apq_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire apq_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               not_empty,
    output apq_pkg::cmd_t      head
);

    localparam int PW = (apq_pkg::QUEUE_DEPTH > 1) ? $clog2(apq_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(apq_pkg::QUEUE_DEPTH + 1);

    apq_pkg::cmd_t   slot_reg [apq_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wptr_reg, wptr_next;
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   cnt_reg,  cnt_next;

    assign full      = (cnt_reg == CW'(apq_pkg::QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(apq_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(apq_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // payload slots, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: src/apq_back.sv
// apq_back: executes queued commands against the entry table (scan, shift, append).
// Depends on apq_pkg; owns the value and priority memories.
`default_nettype none

module apq_back #(
    parameter int CAPACITY      = 64,
    parameter int PRIORITY_BITS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cmd_valid,
    input  wire apq_pkg::cmd_t                       cmd,
    output logic                                     cmd_pop,
    output logic                                     done,
    output logic signed [apq_pkg::VALUE_W-1:0]       out_value,
    output logic [apq_pkg::ITEM_PRI_W-1:0]           out_priority,
    output logic [apq_pkg::STATUS_W-1:0]             status,
    output logic [apq_pkg::OCC_W-1:0]                occupancy
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PB = PRIORITY_BITS;

    // entry table
    logic signed [apq_pkg::VALUE_W-1:0] val_mem [CAPACITY];
    logic [PB-1:0]                      pri_mem [CAPACITY];

    logic                               mem_we;
    logic [AW-1:0]                      mem_waddr;
    logic signed [apq_pkg::VALUE_W-1:0] mem_wval;
    logic [PB-1:0]                      mem_wpri;
    logic                               mem_re;
    logic [AW-1:0]                      mem_raddr;
    logic signed [apq_pkg::VALUE_W-1:0] rd_val_reg;
    logic [PB-1:0]                      rd_pri_reg;

    // control and working registers
    apq_pkg::bk_state_t                 state_reg, state_next;
    apq_pkg::op_t                       op_reg, op_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [CW-1:0]                      rd_addr_reg, rd_addr_next;
    logic                               rvalid_reg, rvalid_next;
    logic [AW-1:0]                      ridx_reg, ridx_next;
    logic [AW-1:0]                      wr_addr_reg, wr_addr_next;
    logic [AW-1:0]                      best_idx_reg, best_idx_next;
    logic signed [apq_pkg::VALUE_W-1:0] best_val_reg, best_val_next;
    logic [PB-1:0]                      best_pri_reg, best_pri_next;
    logic                               done_reg, done_next;
    logic signed [apq_pkg::VALUE_W-1:0] res_val_reg, res_val_next;
    logic [apq_pkg::ITEM_PRI_W-1:0]     res_pri_reg, res_pri_next;
    logic [apq_pkg::STATUS_W-1:0]       status_reg, status_next;

    logic                               take_new;
    logic                               last_read;
    logic [AW-1:0]                      new_best_idx;
    logic signed [apq_pkg::VALUE_W-1:0] new_best_val;
    logic [PB-1:0]                      new_best_pri;

    assign done         = done_reg;
    assign out_value    = res_val_reg;
    assign out_priority = res_pri_reg;
    assign status       = status_reg;
    assign occupancy    = apq_pkg::OCC_W'(count_reg);

    // best-entry compare on the word returned by the memory
    always_comb
    begin
        take_new = (ridx_reg == '0) || (rd_pri_reg > best_pri_reg) ||
                   ((rd_pri_reg == best_pri_reg) && (rd_val_reg > best_val_reg));
        new_best_idx = take_new ? ridx_reg   : best_idx_reg;
        new_best_val = take_new ? rd_val_reg : best_val_reg;
        new_best_pri = take_new ? rd_pri_reg : best_pri_reg;
        last_read    = (CW'(ridx_reg) + CW'(1) == count_reg);
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        count_next    = count_reg;
        rd_addr_next  = rd_addr_reg;
        rvalid_next   = 1'b0;
        ridx_next     = ridx_reg;
        wr_addr_next  = wr_addr_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        best_pri_next = best_pri_reg;
        done_next     = 1'b0;
        res_val_next  = res_val_reg;
        res_pri_next  = res_pri_reg;
        status_next   = status_reg;
        cmd_pop       = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = wr_addr_reg;
        mem_wval      = rd_val_reg;
        mem_wpri      = rd_pri_reg;
        mem_re        = 1'b0;
        mem_raddr     = rd_addr_reg[AW-1:0];

        unique case (state_reg)
            apq_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    op_next      = cmd.op;
                    res_val_next = '0;
                    res_pri_next = '0;
                    status_next  = apq_pkg::ST_OK;
                    unique case (cmd.op)
                        apq_pkg::OP_ENQ:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = apq_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wval   = cmd.value;
                                mem_wpri   = PB'(cmd.pri);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        apq_pkg::OP_PEEK, apq_pkg::OP_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = apq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rd_addr_next = '0;
                                state_next   = apq_pkg::BK_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            apq_pkg::BK_SCAN:
            begin
                // stream entries out of the table, one read a cycle
                if (rd_addr_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    rvalid_next  = 1'b1;
                    ridx_next    = rd_addr_reg[AW-1:0];
                    rd_addr_next = rd_addr_reg + CW'(1);
                end
                if (rvalid_reg)
                begin
                    best_idx_next = new_best_idx;
                    best_val_next = new_best_val;
                    best_pri_next = new_best_pri;
                    if (last_read)
                    begin
                        res_val_next = new_best_val;
                        res_pri_next = apq_pkg::ITEM_PRI_W'(new_best_pri);
                        if (op_reg == apq_pkg::OP_DEQ)
                        begin
                            rd_addr_next = CW'(new_best_idx) + CW'(1);
                            wr_addr_next = new_best_idx;
                            rvalid_next  = 1'b0;
                            state_next   = apq_pkg::BK_SHIFT;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = apq_pkg::BK_IDLE;
                        end
                    end
                end
            end

            apq_pkg::BK_SHIFT:
            begin
                // close the gap: read entry k+1, write it to k in the cycle after the read
                if (rvalid_reg)
                begin
                    mem_we       = 1'b1;
                    wr_addr_next = wr_addr_reg + AW'(1);
                end
                if (rd_addr_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    rvalid_next  = 1'b1;
                    rd_addr_next = rd_addr_reg + CW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    done_next  = 1'b1;
                    state_next = apq_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = apq_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= apq_pkg::BK_IDLE;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            op_reg     <= apq_pkg::OP_NOP;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
            done_reg   <= done_next;
            op_reg     <= op_next;
        end
    end

    // working and result payload, no reset
    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        ridx_reg     <= ridx_next;
        wr_addr_reg  <= wr_addr_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        best_pri_reg <= best_pri_next;
        res_val_reg  <= res_val_next;
        res_pri_reg  <= res_pri_next;
        status_reg   <= status_next;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            val_mem[mem_waddr] <= mem_wval;
            pri_mem[mem_waddr] <= mem_wpri;
        end
        if (mem_re)
        begin
            rd_val_reg <= val_mem[mem_raddr];
            rd_pri_reg <= pri_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/array_priority_queue.sv
// array_priority_queue: top level, front decode + command queue + table back end.
// Depends on apq_pkg, apq_front, apq_fifo, apq_back.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------
//  command   | start, busy (take: !busy) | action, item_value, item_priority
//  result    | done (one-cycle strobe)   | out_value, out_priority, status, occupancy
//
// Enqueue, no-op, and empty/full cases: the command passes the command queue and
// the back end registers the result from its idle state. Peek: the back end scans
// the table, reading one entry a cycle from the table memory. Dequeue: that scan,
// then entries above the best index shift down. busy is high while the two-entry
// command queue is full. rst_n clears the table count; entries are not cleared.
// The result side has no stall: done is high for one cycle per result.
`default_nettype none

module array_priority_queue #(
    parameter int CAPACITY      = 64,
    parameter int PRIORITY_BITS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [apq_pkg::ACTION_W-1:0]        action,
    input  wire logic signed [apq_pkg::VALUE_W-1:0]  item_value,
    input  wire logic [apq_pkg::ITEM_PRI_W-1:0]      item_priority,
    output logic                                     done,
    output logic signed [apq_pkg::VALUE_W-1:0]       out_value,
    output logic [apq_pkg::ITEM_PRI_W-1:0]           out_priority,
    output logic [apq_pkg::STATUS_W-1:0]             status,
    output logic [apq_pkg::OCC_W-1:0]                occupancy
);

    logic          push;
    apq_pkg::cmd_t push_cmd;
    logic          queue_full;
    logic          queue_has;
    apq_pkg::cmd_t queue_head;
    logic          queue_pop;

    apq_front u_front (
        .start         (start),
        .action        (action),
        .item_value    (item_value),
        .item_priority (item_priority),
        .queue_full    (queue_full),
        .busy          (busy),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    apq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (queue_pop),
        .full      (queue_full),
        .not_empty (queue_has),
        .head      (queue_head)
    );

    apq_back #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (queue_has),
        .cmd          (queue_head),
        .cmd_pop      (queue_pop),
        .done         (done),
        .out_value    (out_value),
        .out_priority (out_priority),
        .status       (status),
        .occupancy    (occupancy)
    );

endmodule

`default_nettype wire

FILE: src/apq_checker.sv
// apq_checker: port-level assertions for array_priority_queue, bound to the top.
// Depends on apq_pkg and array_priority_queue.
`default_nettype none

module apq_checker #(
    parameter int CAPACITY = 64
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               done,
    input wire logic signed [apq_pkg::VALUE_W-1:0] out_value,
    input wire logic [apq_pkg::ITEM_PRI_W-1:0]     out_priority,
    input wire logic [apq_pkg::STATUS_W-1:0]       status,
    input wire logic [apq_pkg::OCC_W-1:0]          occupancy
);

    // occupancy only moves together with a result
    a_occ_moves_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(occupancy) |-> done)
        else $error("occupancy changed without a result");

    // an empty report means the table really is empty and carries no entry
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == apq_pkg::ST_EMPTY) |->
            (occupancy == '0 && out_value == '0 && out_priority == '0))
        else $error("empty result with data or nonzero occupancy");

    // a dropped enqueue only happens at capacity and leaves it there
    a_full_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == apq_pkg::ST_FULL) |->
            (occupancy == apq_pkg::OCC_W'(CAPACITY) && $stable(occupancy)))
        else $error("full result below capacity");

    // status on a result is always one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == apq_pkg::ST_OK || status == apq_pkg::ST_EMPTY ||
                  status == apq_pkg::ST_FULL))
        else $error("undefined status code on a result");

endmodule

bind array_priority_queue apq_checker #(
    .CAPACITY (CAPACITY)
) u_apq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .done         (done),
    .out_value    (out_value),
    .out_priority (out_priority),
    .status       (status),
    .occupancy    (occupancy)
);

`default_nettype wire
